>>> rtl/drac_pkg.sv
// ----------------------------------------------------------------------------
// drac_pkg
// Shared types and constants for the domain region access checker: opcodes,
// status codes, sequencer states, region record and shared adder interface.
// ----------------------------------------------------------------------------
package drac_pkg;

  // Fixed field widths
  localparam int ADDR_W = 64;
  localparam int DOM_W  = 8;
  localparam int PERM_W = 8;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CHECK  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_STATE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_CMP_LO,
    S_CMP_HI
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_mode_t;

  typedef struct packed {
    alu_mode_t         mode;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] sum;
    logic              carry;
  } alu_rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [PERM_W-1:0] rights;
  } region_t;

endpackage

>>> rtl/drac_ram.sv
// ----------------------------------------------------------------------------
// drac_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module drac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data while not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/drac_alu.sv
// ----------------------------------------------------------------------------
// drac_alu
// Shared 64-bit adder. Adds for the access end address and subtracts for the
// bound compares; carry out set on subtract means a >= b.
// ----------------------------------------------------------------------------
module drac_alu (
  input  drac_pkg::alu_req_t req,
  output drac_pkg::alu_rsp_t rsp
);
  import drac_pkg::*;

  logic [ADDR_W-1:0] b_eff;
  logic [ADDR_W:0]   total;

  // Invert and add one for subtract
  always_comb begin
    b_eff = (req.mode == ALU_SUB) ? ~req.b : req.b;
    total = {1'b0, req.a} + {1'b0, b_eff} + {{ADDR_W{1'b0}}, (req.mode == ALU_SUB)};
    rsp.sum   = total[ADDR_W-1:0];
    rsp.carry = total[ADDR_W];
  end

endmodule

>>> rtl/domain_region_access_checker.sv
// ----------------------------------------------------------------------------
// domain_region_access_checker
// Protection table of domains with per-domain address regions; creates,
// extends and removes domains and checks accesses against their regions.
// ----------------------------------------------------------------------------
// Sequence: after accept the region count is read in S_LOOKUP; create, add,
//   remove and checks decided without a region walk strobe their result from
//   S_DECIDE; a check that walks k regions (k <= REGIONS_PER_DOMAIN) passes
//   S_CMP_LO and S_CMP_HI per region. Transactions do not overlap; the walk is
//   paced by the single shared 64-bit adder (two bound compares per region)
//   behind the registered region RAM read. busy drops in the strobe cycle.
// Reset: synchronous, clears all domains to inactive; region RAM is not cleared.
// ----------------------------------------------------------------------------
module domain_region_access_checker #(
  parameter int NUM_DOMAINS        = 16,
  parameter int REGIONS_PER_DOMAIN = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [drac_pkg::OP_W-1:0]     in_op,
  input  logic [drac_pkg::DOM_W-1:0]    in_domain,
  input  logic [drac_pkg::ADDR_W-1:0]   in_region_start,
  input  logic [drac_pkg::ADDR_W-1:0]   in_region_end,
  input  logic [drac_pkg::PERM_W-1:0]   in_region_perms,
  input  logic [drac_pkg::ADDR_W-1:0]   in_access_addr,
  input  logic [drac_pkg::ADDR_W-1:0]   in_access_size,
  input  logic [drac_pkg::PERM_W-1:0]   in_access_kind,
  output logic                          out_valid,
  output logic [drac_pkg::STAT_W-1:0]   out_status,
  output logic                          out_allowed
);
  import drac_pkg::*;

  localparam int DW = $clog2(NUM_DOMAINS);
  localparam int RW = (REGIONS_PER_DOMAIN > 1) ? $clog2(REGIONS_PER_DOMAIN) : 1;
  localparam int CW = $clog2(REGIONS_PER_DOMAIN + 1);
  localparam int SW = $clog2(NUM_DOMAINS * REGIONS_PER_DOMAIN);
  localparam int RGW = $bits(region_t);

  // Sequencer and transaction registers
  state_t            state_r, state_nxt;
  op_t               op_r;
  logic [DOM_W-1:0]  dom_r;
  logic [ADDR_W-1:0] rstart_r, rend_r, addr_r, size_r;
  logic [PERM_W-1:0] rperm_r, kind_r;
  logic [ADDR_W-1:0] last_r, last_nxt;
  logic              lo_ok_r, lo_ok_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [NUM_DOMAINS-1:0] active_r, active_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_allowed_r, out_allowed_nxt;

  // Memory and adder hookup
  logic              cnt_re, cnt_we;
  logic [CW-1:0]     cnt_wdata, cnt_rdata;
  logic              rg_re, rg_we;
  logic [SW-1:0]     rg_raddr, rg_waddr;
  region_t           rg_wdata, rg_q;
  logic [RGW-1:0]    rg_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  // Decision terms
  logic              accept;
  logic [DW-1:0]     dom_idx;
  logic              in_range, dom_act, check_zero, cnt_full, cnt_empty;
  logic              walk, perm_ok, hit, last_idx;
  logic [CW-1:0]     idx_inc;

  function automatic logic [SW-1:0] slot_addr(input logic [DW-1:0] d,
                                               input logic [RW-1:0] i);
    slot_addr = SW'(d) * SW'(REGIONS_PER_DOMAIN) + SW'(i);
  endfunction

  assign accept  = start && !busy;
  assign busy    = (state_r != S_IDLE);
  assign rg_q    = rg_rdata;

  assign dom_idx    = dom_r[DW-1:0];
  assign in_range   = ({1'b0, dom_r} < (DOM_W + 1)'(NUM_DOMAINS));
  assign dom_act    = active_r[dom_idx];
  assign check_zero = (op_r == OP_CHECK) && (dom_r == '0);
  assign cnt_full   = (cnt_rdata >= CW'(REGIONS_PER_DOMAIN));
  assign cnt_empty  = (cnt_rdata == '0);
  assign walk       = !check_zero && in_range && (op_r == OP_CHECK) && dom_act && !cnt_empty;
  assign idx_inc    = idx_r + 1'b1;
  assign last_idx   = (idx_inc == cnt_rdata);
  assign perm_ok    = ((rg_q.rights & kind_r) == kind_r);
  assign hit        = lo_ok_r && alu_rsp.carry && perm_ok;

  // Region count per domain
  drac_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_DOMAINS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (dom_idx),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (dom_idx),
    .rdata (cnt_rdata)
  );

  // Region bounds and rights
  drac_ram #(
    .WIDTH (RGW),
    .DEPTH (NUM_DOMAINS * REGIONS_PER_DOMAIN)
  ) u_rg_ram (
    .clk   (clk),
    .we    (rg_we),
    .waddr (rg_waddr),
    .wdata (rg_wdata),
    .re    (rg_re),
    .raddr (rg_raddr),
    .rdata (rg_rdata)
  );

  // Shared adder
  drac_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   state_nxt = accept ? S_LOOKUP : S_IDLE;
      S_LOOKUP: state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = walk ? S_CMP_LO : S_IDLE;
      S_CMP_LO: state_nxt = S_CMP_HI;
      S_CMP_HI: state_nxt = (hit || last_idx) ? S_IDLE : S_CMP_LO;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath control and results
  always_comb begin
    cnt_re          = 1'b0;
    cnt_we          = 1'b0;
    cnt_wdata       = '0;
    rg_re           = 1'b0;
    rg_raddr        = slot_addr(dom_idx, idx_r[RW-1:0]);
    rg_we           = 1'b0;
    rg_waddr        = slot_addr(dom_idx, cnt_rdata[RW-1:0]);
    rg_wdata.lo     = rstart_r;
    rg_wdata.hi     = rend_r;
    rg_wdata.rights = rperm_r;
    alu_req.mode    = ALU_ADD;
    alu_req.a       = addr_r;
    alu_req.b       = size_r;
    last_nxt        = last_r;
    lo_ok_nxt       = lo_ok_r;
    idx_nxt         = idx_r;
    active_nxt      = active_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = ST_OK;
    out_allowed_nxt = 1'b0;
    case (state_r)
      S_LOOKUP: begin
        // Read count, form access end (wraps mod 2^64)
        cnt_re   = 1'b1;
        last_nxt = alu_rsp.sum;
      end
      S_DECIDE: begin
        out_valid_nxt = !walk;
        if (check_zero) begin
          out_allowed_nxt = 1'b1;
        end else if (!in_range) begin
          out_status_nxt = ST_RANGE;
        end else begin
          case (op_r)
            OP_CREATE: begin
              if (dom_act) begin
                out_status_nxt = ST_STATE;
              end else begin
                active_nxt[dom_idx] = 1'b1;
                cnt_we              = 1'b1;
              end
            end
            OP_ADD: begin
              if (!dom_act) begin
                out_status_nxt = ST_STATE;
              end else if (cnt_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                rg_we     = 1'b1;
                cnt_we    = 1'b1;
                cnt_wdata = cnt_rdata + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (!dom_act) begin
                out_status_nxt = ST_STATE;
              end else begin
                active_nxt[dom_idx] = 1'b0;
              end
            end
            OP_CHECK: begin
              if (!dom_act) begin
                out_status_nxt = ST_STATE;
              end else if (!cnt_empty) begin
                // Start the walk at the first region
                rg_re    = 1'b1;
                rg_raddr = slot_addr(dom_idx, '0);
                idx_nxt  = '0;
              end
            end
            default: out_status_nxt = ST_OK;
          endcase
        end
      end
      S_CMP_LO: begin
        // addr >= lo
        alu_req.mode = ALU_SUB;
        alu_req.a    = addr_r;
        alu_req.b    = rg_q.lo;
        lo_ok_nxt    = alu_rsp.carry;
      end
      S_CMP_HI: begin
        // hi >= last; prefetch the next region on a miss before the last one
        alu_req.mode = ALU_SUB;
        alu_req.a    = rg_q.hi;
        alu_req.b    = last_r;
        if (hit || last_idx) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = hit;
        end else begin
          rg_re    = 1'b1;
          rg_raddr = slot_addr(dom_idx, idx_inc[RW-1:0]);
          idx_nxt  = idx_inc;
        end
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(in_op);
      dom_r    <= in_domain;
      rstart_r <= in_region_start;
      rend_r   <= in_region_end;
      rperm_r  <= in_region_perms;
      addr_r   <= in_access_addr;
      size_r   <= in_access_size;
      kind_r   <= in_access_kind;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    last_r        <= last_nxt;
    lo_ok_r       <= lo_ok_nxt;
    idx_r         <= idx_nxt;
    out_status_r  <= out_status_nxt;
    out_allowed_r <= out_allowed_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_allowed = out_allowed_r;

  // A result only follows a transaction in flight
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != S_IDLE))
    else $error("result strobe without a transaction in flight");

  // A permitted access always reports ok
  a_allowed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_allowed_r) |-> (out_status_r == ST_OK))
    else $error("allowed result with non-ok status");

  // Region writes go only to an active domain with a free slot
  a_region_write: assert property (@(posedge clk) disable iff (!rst_n)
    rg_we |-> (dom_act && !cnt_full && in_range))
    else $error("region write to inactive or full domain");

  // The walk never passes the domain's region count
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP_HI) |-> (idx_r < cnt_rdata))
    else $error("region walk beyond region count");

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("not busy after accept");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the domain region access checker. Drives create,
// add, remove and check transactions through the start/busy port, predicts
// each status/allowed result from a shadow protection table and compares it
// with the strobed result, in order.
// ----------------------------------------------------------------------------
module testbench;
  import drac_pkg::*;

  localparam int NUM_DOMAINS        = 16;
  localparam int REGIONS_PER_DOMAIN = 8;
  localparam int ITEMS_PER_PHASE    = 170;
  localparam int STALL_LIMIT        = 2000;
  localparam int MAX_REPORTS        = 10;

  typedef struct packed {
    status_t status;
    logic    allowed;
  } verdict_t;

  // Shadow protection table and in-order store of predicted verdicts
  class access_scoreboard;
    bit                domain_on[NUM_DOMAINS];
    int unsigned       used[NUM_DOMAINS];
    bit [ADDR_W-1:0]   lo_tab[NUM_DOMAINS][REGIONS_PER_DOMAIN];
    bit [ADDR_W-1:0]   hi_tab[NUM_DOMAINS][REGIONS_PER_DOMAIN];
    bit [PERM_W-1:0]   rights_tab[NUM_DOMAINS][REGIONS_PER_DOMAIN];
    verdict_t          verdict_q[$];
    int                mismatches;

    function int pending();
      return verdict_q.size();
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", what);
    endfunction

    // Apply one accepted transaction to the table and queue its verdict
    function void note_request(op_t op, logic [DOM_W-1:0] dom,
                               logic [ADDR_W-1:0] rs, logic [ADDR_W-1:0] re,
                               logic [PERM_W-1:0] rp, logic [ADDR_W-1:0] aa,
                               logic [ADDR_W-1:0] asz, logic [PERM_W-1:0] ak);
      verdict_t        v;
      int              d;
      bit [ADDR_W-1:0] last;
      v.status  = ST_OK;
      v.allowed = 1'b0;
      d = int'(dom);
      if (op == OP_CHECK && dom == '0) begin
        v.allowed = 1'b1;
      end else if (d >= NUM_DOMAINS) begin
        v.status = ST_RANGE;
      end else begin
        case (op)
          OP_CREATE: begin
            if (domain_on[d]) v.status = ST_STATE;
            else begin
              domain_on[d] = 1'b1;
              used[d]      = 0;
            end
          end
          OP_ADD: begin
            if (!domain_on[d]) v.status = ST_STATE;
            else if (used[d] >= REGIONS_PER_DOMAIN) v.status = ST_FULL;
            else begin
              lo_tab[d][used[d]]     = rs;
              hi_tab[d][used[d]]     = re;
              rights_tab[d][used[d]] = rp;
              used[d]++;
            end
          end
          OP_REMOVE: begin
            if (!domain_on[d]) v.status = ST_STATE;
            else begin
              domain_on[d] = 1'b0;
              used[d]      = 0;
            end
          end
          default: begin
            // walk regions; the access end wraps at 64 bits
            if (!domain_on[d]) v.status = ST_STATE;
            else begin
              last = aa + asz;
              for (int i = 0; i < used[d]; i++) begin
                if (aa >= lo_tab[d][i] && last <= hi_tab[d][i] &&
                    (rights_tab[d][i] & ak) == ak)
                  v.allowed = 1'b1;
              end
            end
          end
        endcase
      end
      verdict_q.push_back(v);
    endfunction

    // Compare one strobed result against the oldest prediction
    function void check_verdict(logic [STAT_W-1:0] status, logic allowed);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        flag($sformatf("unexpected result status=%0d allowed=%0b", status, allowed));
        return;
      end
      want = verdict_q.pop_front();
      if (status !== want.status || allowed !== want.allowed)
        flag($sformatf("status exp=%0d act=%0d, allowed exp=%0b act=%0b",
                       want.status, status, want.allowed, allowed));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_op = '0;
  logic [DOM_W-1:0]  in_domain = '0;
  logic [ADDR_W-1:0] in_region_start = '0;
  logic [ADDR_W-1:0] in_region_end = '0;
  logic [PERM_W-1:0] in_region_perms = '0;
  logic [ADDR_W-1:0] in_access_addr = '0;
  logic [ADDR_W-1:0] in_access_size = '0;
  logic [PERM_W-1:0] in_access_kind = '0;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic              out_allowed;

  access_scoreboard sb;

  // Last region sent to each domain number, used to aim checks inside it
  bit [ADDR_W-1:0] aim_lo[256];
  bit [ADDR_W-1:0] aim_hi[256];
  bit [PERM_W-1:0] aim_perms[256];

  domain_region_access_checker #(
    .NUM_DOMAINS       (NUM_DOMAINS),
    .REGIONS_PER_DOMAIN(REGIONS_PER_DOMAIN)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_domain      (in_domain),
    .in_region_start(in_region_start),
    .in_region_end  (in_region_end),
    .in_region_perms(in_region_perms),
    .in_access_addr (in_access_addr),
    .in_access_size (in_access_size),
    .in_access_kind (in_access_kind),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_allowed    (out_allowed)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Check strobed results, then note the transaction accepted at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_verdict(out_status, out_allowed);
      if (start && !busy)
        sb.note_request(op_t'(in_op), in_domain, in_region_start, in_region_end,
                        in_region_perms, in_access_addr, in_access_size,
                        in_access_kind);
    end
  end

  // Abort when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Present one transaction and hold it until accepted
  task automatic send_item(input op_t op, input logic [DOM_W-1:0] dom,
                           input logic [ADDR_W-1:0] rs, input logic [ADDR_W-1:0] re,
                           input logic [PERM_W-1:0] rp, input logic [ADDR_W-1:0] aa,
                           input logic [ADDR_W-1:0] asz, input logic [PERM_W-1:0] ak);
    in_op           <= op;
    in_domain       <= dom;
    in_region_start <= rs;
    in_region_end   <= re;
    in_region_perms <= rp;
    in_access_addr  <= aa;
    in_access_size  <= asz;
    in_access_kind  <= ak;
    start           <= 1'b1;
    if (op == OP_ADD) begin
      aim_lo[dom]    = rs;
      aim_hi[dom]    = re;
      aim_perms[dom] = rp;
    end
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending until every predicted result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Build one random transaction, mostly aimed at live domains and regions
  task automatic send_random();
    op_t               op;
    logic [DOM_W-1:0]  dom;
    logic [ADDR_W-1:0] rs, re, aa, asz, span, off, room;
    logic [PERM_W-1:0] rp, ak;
    int                pick;
    pick = $urandom_range(99);
    op = (pick < 14) ? OP_CREATE : (pick < 42) ? OP_ADD :
         (pick < 50) ? OP_REMOVE : OP_CHECK;
    pick = $urandom_range(99);
    if (pick < 8) dom = DOM_W'($urandom_range(255));
    else if (pick < 14) dom = '0;
    else dom = DOM_W'($urandom_range(1, NUM_DOMAINS - 1));

    // region bounds: ordinary spans, plus ones from zero, open-ended and inverted ones
    rs = rand64();
    rp = PERM_W'($urandom());
    case ($urandom_range(9))
      0: begin
        rs = '0;
        re = rand64();
      end
      1: re = '1;
      2: re = rs - ADDR_W'($urandom_range(1, 255));
      default: begin
        if ($urandom_range(3) == 0) re = rs + (rand64() >> $urandom_range(1, 63));
        else re = rs + ADDR_W'($urandom_range(1, 65535));
      end
    endcase

    aa  = rand64();
    asz = rand64() >> $urandom_range(0, 63);
    ak  = PERM_W'($urandom());
    if (op == OP_CHECK && $urandom_range(99) < 65) begin
      // aim inside the domain's last region, then sometimes step just outside
      span = (aim_hi[dom] >= aim_lo[dom]) ? aim_hi[dom] - aim_lo[dom] : '0;
      off  = (span == '0) ? '0 : rand64() % span;
      room = span - off;
      asz  = (room == '1) ? rand64() : rand64() % (room + 1);
      aa   = aim_lo[dom] + off;
      ak   = aim_perms[dom] & PERM_W'($urandom());
      case ($urandom_range(7))
        0: asz = asz + 1;
        1: ak = ak | PERM_W'(1 << $urandom_range(7));
        2: aa = aim_lo[dom] - 1;
        default: ;
      endcase
    end
    send_item(op, dom, rs, re, rp, aa, asz, ak);
  endtask

  initial begin
    int idle_pct[3];
    idle_pct = '{18, 45, 0};
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: range and state errors, a full domain, wrap and mask cases
    send_item(OP_CHECK,  8'd0,   '0, '0, '0, 64'h10, 64'h10, 8'hFF);
    send_item(OP_CREATE, 8'd255, '0, '0, '0, '0, '0, '0);
    send_item(OP_CHECK,  8'd200, '0, '0, '0, '0, '0, '0);
    send_item(OP_ADD,    8'd3,   64'h1000, 64'h2000, 8'h05, '0, '0, '0);
    send_item(OP_REMOVE, 8'd3,   '0, '0, '0, '0, '0, '0);
    send_item(OP_CHECK,  8'd3,   '0, '0, '0, 64'h1000, 64'h10, 8'h00);
    send_item(OP_CREATE, 8'd3,   '0, '0, '0, '0, '0, '0);
    send_item(OP_CREATE, 8'd3,   '0, '0, '0, '0, '0, '0);
    send_item(OP_ADD,    8'd3,   64'h1000, 64'h2000, 8'h05, '0, '0, '0);
    send_item(OP_ADD,    8'd3,   '0, '1, 8'h00, '0, '0, '0);
    send_item(OP_ADD,    8'd3,   64'hFFFF_FFFF_FFFF_FF00, '1, 8'hFF, '0, '0, '0);
    send_item(OP_ADD,    8'd3,   64'h8000_0000_0000_0000, 64'h8000_0000_0000_0010,
              8'h80, '0, '0, '0);
    for (int i = 4; i < REGIONS_PER_DOMAIN; i++)
      send_item(OP_ADD, 8'd3, ADDR_W'(i) << 12, (ADDR_W'(i) << 12) + 64'h100,
                PERM_W'(1 << i), '0, '0, '0);
    send_item(OP_ADD,    8'd3,   64'h0, 64'h10, 8'hFF, '0, '0, '0);
    send_item(OP_CHECK,  8'd3,   '0, '0, '0, 64'h1000, 64'h1000, 8'h05);
    send_item(OP_CHECK,  8'd3,   '0, '0, '0, 64'h1000, 64'h1001, 8'h04);
    send_item(OP_CHECK,  8'd3,   '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, 8'hFF);
    send_item(OP_CHECK,  8'd3,   '0, '0, '0, 64'h5, 64'h0, 8'h00);
    send_item(OP_CHECK,  8'd3,   '0, '0, '0, 64'h8000_0000_0000_0000, 64'h10, 8'h81);
    send_item(OP_REMOVE, 8'd3,   '0, '0, '0, '0, '0, '0);
    send_item(OP_CHECK,  8'd3,   '0, '0, '0, 64'h1000, 64'h10, 8'h00);
    send_item(OP_CREATE, 8'd0,   '0, '0, '0, '0, '0, '0);
    drain();

    // Random phases: before each item the sender keeps pausing with a chance of
    // 18, then 45, then 0 percent; drain between phases
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        while ($urandom_range(99) < idle_pct[ph]) pause(1);
        send_random();
      end
      drain();
    end

    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
